### hdl/yaw_scale_translate_matrix_assert.svh
// Assertion macros shared by the matrix baker modules.
`ifndef YAW_SCALE_TRANSLATE_MATRIX_ASSERT_SVH
`define YAW_SCALE_TRANSLATE_MATRIX_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define YSTM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ystm assertion failed");

// Next-cycle implication, checked outside reset
`define YSTM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ystm assertion failed");

`endif

### hdl/ystm_pkg.sv
package ystm_pkg;

    // CORDIC layout: 18 rotations, three per register stage
    localparam int CORDIC_STEPS    = 18;
    localparam int STEPS_PER_STAGE = 3;
    localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;

    // Angle reduce + CORDIC stages + round + multiply + saturate
    localparam int PIPE_DEPTH = CORDIC_STAGES + 4;

    localparam int XY_W = 34;
    localparam int Z_W  = 26;

    // Reciprocal of the CORDIC gain, 30 fraction bits
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

    // Rotator state carried between CORDIC stages
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   flip;
    } t_cordic;

    // Fields that ride alongside the rotator
    typedef struct packed {
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
        logic signed [15:0] scale_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [15:0]        tint_red;
        logic [15:0]        tint_green;
        logic [15:0]        tint_blue;
    } t_side;

    // Arctangent of 2^-i in units of 2^-24 turn
    function automatic logic signed [Z_W-1:0] ystm_atan(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = Z_W'(2097152);
            5'd1:    v = Z_W'(1238021);
            5'd2:    v = Z_W'(654136);
            5'd3:    v = Z_W'(332050);
            5'd4:    v = Z_W'(166669);
            5'd5:    v = Z_W'(83416);
            5'd6:    v = Z_W'(41718);
            5'd7:    v = Z_W'(20860);
            5'd8:    v = Z_W'(10430);
            5'd9:    v = Z_W'(5215);
            5'd10:   v = Z_W'(2608);
            5'd11:   v = Z_W'(1304);
            5'd12:   v = Z_W'(652);
            5'd13:   v = Z_W'(326);
            5'd14:   v = Z_W'(163);
            5'd15:   v = Z_W'(81);
            5'd16:   v = Z_W'(41);
            5'd17:   v = Z_W'(20);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### hdl/ystm_cordic_stage.sv
module ystm_cordic_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  ystm_pkg::t_cordic i_data,
    input  logic [4:0]       i_step_base,
    output logic             o_vld,
    output ystm_pkg::t_cordic o_data
);
    import ystm_pkg::*;

    t_cordic n_data;
    t_cordic r_data;
    logic    r_vld;

    // Three rotation-mode micro-rotations, each shift by its own step index
    always_comb begin
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        logic [4:0]             sh;
        n_data = i_data;
        for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            sh = 5'(i_step_base + 5'(j));
            dx = n_data.y >>> sh;
            dy = n_data.x >>> sh;
            if (!n_data.z[Z_W-1]) begin
                n_data.x = n_data.x - dx;
                n_data.y = n_data.y + dy;
                n_data.z = n_data.z - ystm_atan(sh);
            end else begin
                n_data.x = n_data.x + dx;
                n_data.y = n_data.y - dy;
                n_data.z = n_data.z + ystm_atan(sh);
            end
        end
    end

    // Stage register; only the valid bit is reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_data <= n_data;
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

### hdl/ystm_scale_mult.sv
`include "yaw_scale_translate_matrix_assert.svh"

module ystm_scale_mult (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  logic signed [15:0] i_cos,
    input  logic signed [15:0] i_sin,
    input  logic signed [15:0] i_scale_x,
    input  logic signed [15:0] i_scale_z,
    output logic               o_vld,
    output logic signed [15:0] o_c0r0,
    output logic signed [15:0] o_c0r2,
    output logic signed [15:0] o_c2r0,
    output logic signed [15:0] o_c2r2
);
    import ystm_pkg::*;

    logic signed [16:0] w_cos;
    logic signed [16:0] w_sin;
    logic signed [16:0] w_nsin;

    logic               r_vld1;
    logic signed [32:0] r_p00;
    logic signed [32:0] r_p02;
    logic signed [32:0] r_p20;
    logic signed [32:0] r_p22;

    logic               r_vld2;
    logic signed [15:0] r_c0r0;
    logic signed [15:0] r_c0r2;
    logic signed [15:0] r_c2r0;
    logic signed [15:0] r_c2r2;

    // Round Q10.23 to Q8.8, half up, then clamp to 16 bits
    function automatic logic signed [15:0] rnd_sat(input logic signed [32:0] p);
        logic signed [33:0] s;
        logic signed [18:0] q;
        s = 34'(p) + 34'sd16384;
        q = 19'(s >>> 15);
        if (q > 19'sd32767) begin
            return 16'sh7fff;
        end else if (q < -19'sd32768) begin
            return 16'sh8000;
        end
        return 16'(q);
    endfunction

    // Q1.15 factors; the negated sine can reach +1.0
    assign w_cos  = 17'(i_cos);
    assign w_sin  = 17'(i_sin);
    assign w_nsin = -w_sin;

    // Multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
        end
        r_p00 <= w_cos  * 33'(i_scale_x);
        r_p02 <= w_nsin * 33'(i_scale_x);
        r_p20 <= w_sin  * 33'(i_scale_z);
        r_p22 <= w_cos  * 33'(i_scale_z);
    end

    // Round and saturate stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
        end else begin
            r_vld2 <= r_vld1;
        end
        r_c0r0 <= rnd_sat(r_p00);
        r_c0r2 <= rnd_sat(r_p02);
        r_c2r0 <= rnd_sat(r_p20);
        r_c2r2 <= rnd_sat(r_p22);
    end

    assign o_vld  = r_vld2;
    assign o_c0r0 = r_c0r0;
    assign o_c0r2 = r_c0r2;
    assign o_c2r0 = r_c2r0;
    assign o_c2r2 = r_c2r2;

    // Zero cosine gives zero diagonal products once through the multiply and round/saturate registers
    `YSTM_ASSERT_IMP(a_zero_cos, o_vld && $past(i_vld, 2) && $past(i_cos, 2) == 16'sd0, o_c0r0 == 16'sd0 && o_c2r2 == 16'sd0)
    // A valid product in the multiply stage register is delivered through the round/saturate register
    `YSTM_ASSERT_NEXT(a_vld_follow, r_vld1, o_vld)

endmodule

### hdl/yaw_scale_translate_matrix.sv
// Yaw/scale/translate model matrix baker. One instance description goes in per
// clock cycle and its matrix entries come out through 1 angle-reduce stage, 6
// CORDIC stages of 3 rotations each for the 18-step sine/cosine, a round stage,
// a multiply stage and a round/saturate stage. busy is never
// raised: every start is taken, and each result sits on the o_ ports for one
// cycle with o_valid high. The receiver cannot hold results off, so it must
// take every transfer in the cycle it is shown.
`include "yaw_scale_translate_matrix_assert.svh"

module yaw_scale_translate_matrix (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [15:0]        i_yaw_angle,
    input  logic signed [15:0] i_scale_x,
    input  logic signed [15:0] i_scale_y,
    input  logic signed [15:0] i_scale_z,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic [15:0]        i_tint_red,
    input  logic [15:0]        i_tint_green,
    input  logic [15:0]        i_tint_blue,
    output logic               o_valid,
    output logic signed [15:0] o_col0_row0,
    output logic signed [15:0] o_col0_row2,
    output logic signed [15:0] o_col1_row1,
    output logic signed [15:0] o_col2_row0,
    output logic signed [15:0] o_col2_row2,
    output logic signed [31:0] o_trans_x,
    output logic signed [31:0] o_trans_y,
    output logic signed [31:0] o_trans_z,
    output logic [15:0]        o_out_red,
    output logic [15:0]        o_out_green,
    output logic [15:0]        o_out_blue
);
    import ystm_pkg::*;

    logic               w_accept;
    logic signed [16:0] w_ang;
    logic signed [16:0] n_ang;
    logic               n_flip;
    t_cordic            n_a;
    t_side              n_side;

    logic               r_a_vld;
    t_cordic            r_a;
    t_side              r_side [PIPE_DEPTH];

    logic               w_cv [CORDIC_STAGES+1];
    t_cordic            w_cd [CORDIC_STAGES+1];

    logic signed [XY_W-1:0] w_xf;
    logic signed [XY_W-1:0] w_yf;
    logic signed [XY_W-1:0] w_xr;
    logic signed [XY_W-1:0] w_yr;
    logic                   r_r_vld;
    logic signed [15:0]     r_cos;
    logic signed [15:0]     r_sin;

    logic                   w_m_vld;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // Fold the angle into a quarter turn either side of zero
    assign w_ang = 17'(signed'(i_yaw_angle));
    always_comb begin
        n_ang  = w_ang;
        n_flip = 1'b0;
        if (w_ang > 17'sd16384) begin
            n_ang  = w_ang - 17'sd32768;
            n_flip = 1'b1;
        end else if (w_ang < -17'sd16384) begin
            n_ang  = w_ang + 17'sd32768;
            n_flip = 1'b1;
        end
        n_a.x    = CORDIC_GAIN;
        n_a.y    = '0;
        n_a.z    = {n_ang[16], n_ang, 8'h00};
        n_a.flip = n_flip;
    end

    assign n_side = '{scale_x: i_scale_x, scale_y: i_scale_y, scale_z: i_scale_z,
                      pos_x: i_pos_x, pos_y: i_pos_y, pos_z: i_pos_z,
                      tint_red: i_tint_red, tint_green: i_tint_green,
                      tint_blue: i_tint_blue};

    // Entry stage and side-band delay line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= w_accept;
        end
        r_a       <= n_a;
        r_side[0] <= n_side;
        for (int k = 1; k < PIPE_DEPTH; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    // CORDIC chain
    assign w_cv[0] = r_a_vld;
    assign w_cd[0] = r_a;
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        ystm_cordic_stage u_stage (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_vld       (w_cv[g]),
            .i_data      (w_cd[g]),
            .i_step_base (5'(g * STEPS_PER_STAGE)),
            .o_vld       (w_cv[g+1]),
            .o_data      (w_cd[g+1])
        );
    end

    // Undo the half-turn fold, round to Q1.15 and clamp
    assign w_xf = w_cd[CORDIC_STAGES].flip ? -w_cd[CORDIC_STAGES].x : w_cd[CORDIC_STAGES].x;
    assign w_yf = w_cd[CORDIC_STAGES].flip ? -w_cd[CORDIC_STAGES].y : w_cd[CORDIC_STAGES].y;
    assign w_xr = (w_xf + XY_W'(16384)) >>> 15;
    assign w_yr = (w_yf + XY_W'(16384)) >>> 15;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_vld <= 1'b0;
        end else begin
            r_r_vld <= w_cv[CORDIC_STAGES];
        end
        if (w_xr > XY_W'(32767)) begin
            r_cos <= 16'sh7fff;
        end else if (w_xr < -XY_W'(32768)) begin
            r_cos <= 16'sh8000;
        end else begin
            r_cos <= 16'(w_xr);
        end
        if (w_yr > XY_W'(32767)) begin
            r_sin <= 16'sh7fff;
        end else if (w_yr < -XY_W'(32768)) begin
            r_sin <= 16'sh8000;
        end else begin
            r_sin <= 16'(w_yr);
        end
    end

    // Products with the scales, rounded and saturated to Q8.8
    ystm_scale_mult u_mult (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (r_r_vld),
        .i_cos     (r_cos),
        .i_sin     (r_sin),
        .i_scale_x (r_side[PIPE_DEPTH-3].scale_x),
        .i_scale_z (r_side[PIPE_DEPTH-3].scale_z),
        .o_vld     (w_m_vld),
        .o_c0r0    (o_col0_row0),
        .o_c0r2    (o_col0_row2),
        .o_c2r0    (o_col2_row0),
        .o_c2r2    (o_col2_row2)
    );

    // Result transfer
    assign o_valid     = w_m_vld;
    assign o_col1_row1 = r_side[PIPE_DEPTH-1].scale_y;
    assign o_trans_x   = r_side[PIPE_DEPTH-1].pos_x;
    assign o_trans_y   = r_side[PIPE_DEPTH-1].pos_y;
    assign o_trans_z   = r_side[PIPE_DEPTH-1].pos_z;
    assign o_out_red   = r_side[PIPE_DEPTH-1].tint_red;
    assign o_out_green = r_side[PIPE_DEPTH-1].tint_green;
    assign o_out_blue  = r_side[PIPE_DEPTH-1].tint_blue;

    // Every result traces back to a rounded sine/cosine through the multiply and round/saturate registers
    `YSTM_ASSERT_IMP(a_out_src, o_valid, $past(r_r_vld, 2))
    // An accepted start enters the CORDIC chain on the next edge
    `YSTM_ASSERT_NEXT(a_entry, w_accept, r_a_vld)

endmodule
